@@ hdl/brcf_pkg.sv @@
// brcf_pkg: shared constants for the bitmap rectangle and circle fill block.
// Map geometry, field widths, stream packing offsets and command codes.
// No dependencies; imported by the top level and its checker.
package brcf_pkg;

    // Map geometry
    localparam int MAX_WIDTH        = 1024;
    localparam int HEIGHT           = 256;
    localparam int RADIUS_FRAC_BITS = 4;

    // Fixed field widths
    localparam int MW_W  = 11;   // map_width register
    localparam int PX_W  = 10;   // pos_x
    localparam int PY_W  = 8;    // pos_y
    localparam int SW_W  = 11;   // size_w
    localparam int SH_W  = 9;    // size_h
    localparam int RQ_W  = 12;   // radius_q
    localparam int CNT_W = 19;   // cells_written

    // Derived widths
    localparam int XW     = $clog2(MAX_WIDTH);          // column index
    localparam int WW     = $clog2(MAX_WIDTH + 1);      // column count / width
    localparam int YW     = $clog2(HEIGHT);             // row index
    localparam int HW     = $clog2(HEIGHT + 1);         // row count
    localparam int RW     = RQ_W - RADIUS_FRAC_BITS;    // integer radius
    localparam int SPAN_W = RW + 1;                     // 2r
    localparam int NC_W   = (WW > SPAN_W) ? WW : SPAN_W;
    localparam int NR_W   = (HW > SPAN_W) ? HW : SPAN_W;
    localparam int SQ_W   = 2 * RW;                     // squared offset
    localparam int LIM_W  = 2 * RQ_W;                   // squared radius_q
    localparam int DST_W  = SQ_W + 1 + 2 * RADIUS_FRAC_BITS;
    localparam int PW     = (PX_W > RW) ? PX_W : RW;    // remainder dividend
    localparam int STEP_W = $clog2(PW + 1);
    localparam int YB_W   = ((PY_W > RW) ? PY_W : RW) + 2;
    localparam int Y_W    = ((YB_W > NR_W + 1) ? YB_W : NR_W + 1) + 1;
    localparam int DY_W   = ((NR_W > RW) ? NR_W : RW) + 2;

    // Stream packing, lowest bit first
    localparam int OFF_VAL = 0;
    localparam int OFF_PX  = OFF_VAL + 1;
    localparam int OFF_PY  = OFF_PX + PX_W;
    localparam int OFF_SW  = OFF_PY + PY_W;
    localparam int OFF_SH  = OFF_SW + SW_W;
    localparam int OFF_RQ  = OFF_SH + SH_W;
    localparam int IN_BITS = OFF_RQ + RQ_W;
    localparam int S_TDATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((CNT_W + 7) / 8) * 8;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_MAP_WIDTH = 1'b0;   // register index held in paddr[2]
    localparam logic [MW_W-1:0] MAP_WIDTH_RST = MW_W'(MAX_WIDTH);

    // Command codes
    localparam logic MODE_RECT   = 1'b0;
    localparam logic MODE_CIRCLE = 1'b1;

    // Largest possible count of one command
    localparam int MAX_CELLS = MAX_WIDTH * HEIGHT;

endpackage

@@ hdl/bitmap_rect_circle_fill.sv @@
// bitmap_rect_circle_fill: one-bit-per-cell map with rectangle and circle fill.
// Each command reduces its start column modulo the map width and walks its region; the
// result may wait on m_tready. Rectangles walk w by h, circles of radius r 2r by 2r, and
// an empty region skips the walk. Throughput: one command at a time, about a cell a cycle
// in the row walk, set by the read, modify and write back of one column word per column.
// Synchronous reset sets map_width to 1024, clears the output and zeroes the map first.
module bitmap_rect_circle_fill
    import brcf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    // Command stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // tdata: set_value[0], pos_x[10:1], pos_y[18:11], size_w[29:19],
    //        size_h[38:30], radius_q[50:39], zero fill above
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // tuser: mode[0]
    input  logic [0:0]            s_tuser,

    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // tdata: cells_written[18:0], zero fill above
    output logic [M_TDATA_W-1:0]  m_tdata,
    // tuser: done_res[0]
    output logic [0:0]            m_tuser,

    // Configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [PDATA_W-1:0]    pwdata,
    output logic [PDATA_W-1:0]    prdata,
    output logic                  pready
);

    typedef enum logic [2:0] {
        ST_CLEAR,   // zero the map, one column a cycle
        ST_IDLE,    // wait for a command
        ST_MOD,     // reduce the start column modulo the map width
        ST_RD,      // issue the column read
        ST_LD,      // take the column word, set up the squares
        ST_ROW,     // walk the rows of the column, one cell a cycle
        ST_WB,      // write the column word back, advance the column
        ST_DONE     // hand the count to the output register
    } state_t;

    // ------------------------------------------------------------------
    // Map memory: one word per column, one bit per row
    // ------------------------------------------------------------------
    logic [HEIGHT-1:0] map_mem [MAX_WIDTH];
    logic [HEIGHT-1:0] rdata_reg;
    logic              mem_we;
    logic [XW-1:0]     mem_waddr;
    logic [HEIGHT-1:0] mem_wdata;

    // Control and working registers
    state_t                   state_reg;
    logic [MW_W-1:0]          map_width_reg;
    logic [XW-1:0]            clr_cnt_reg;
    logic                     mode_reg;
    logic                     val_reg;
    logic [RW-1:0]            r_reg;
    logic [LIM_W-1:0]         lim_reg;
    logic [SQ_W-1:0]          r2_reg;
    logic [NC_W-1:0]          ncol_reg;
    logic [NR_W-1:0]          nrow_reg;
    logic signed [YB_W-1:0]   ybase_reg;
    logic [PW-1:0]            div_reg;
    logic [WW-1:0]            rem_reg;
    logic                     neg_reg;
    logic [STEP_W-1:0]        step_reg;
    logic [XW-1:0]            x_reg;
    logic [NC_W-1:0]          ci_reg;
    logic [NR_W-1:0]          ri_reg;
    logic [SQ_W-1:0]          dx2_reg;
    logic [SQ_W-1:0]          dy2_reg;
    logic [HEIGHT-1:0]        col_reg;
    logic [CNT_W-1:0]         count_reg;
    logic                     m_tvalid_reg;
    logic [CNT_W-1:0]         m_cnt_reg;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MAP_WIDTH) ? PDATA_W'(map_width_reg) : '0;

    // Effective width: zero is used as one, oversize saturates
    logic [WW-1:0] eff_w;
    always_comb begin
        if (map_width_reg == '0) begin
            eff_w = WW'(1);
        end else if (int'(map_width_reg) > MAX_WIDTH) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(map_width_reg);
        end
    end

    // ------------------------------------------------------------------
    // Command unpacking and setup values
    // ------------------------------------------------------------------
    logic                    in_mode;
    logic                    in_val;
    logic [PX_W-1:0]         in_px;
    logic [PY_W-1:0]         in_py;
    logic [SW_W-1:0]         in_sw;
    logic [SH_W-1:0]         in_sh;
    logic [RQ_W-1:0]         in_rq;
    logic [RW-1:0]           in_r;
    logic [NC_W-1:0]         in_ncol;
    logic [NR_W-1:0]         in_nrow;
    logic signed [YB_W-1:0]  in_ybase;
    logic signed [PW:0]      in_xs;
    logic [PW:0]             in_xmag;
    logic                    s_acc;

    assign in_mode = s_tuser[0];
    assign in_val  = s_tdata[OFF_VAL];
    assign in_px   = s_tdata[OFF_PX +: PX_W];
    assign in_py   = s_tdata[OFF_PY +: PY_W];
    assign in_sw   = s_tdata[OFF_SW +: SW_W];
    assign in_sh   = s_tdata[OFF_SH +: SH_W];
    assign in_rq   = s_tdata[OFF_RQ +: RQ_W];
    assign in_r    = in_rq[RQ_W-1 -: RW];

    always_comb begin
        if (in_mode == MODE_CIRCLE) begin
            in_ncol  = NC_W'({in_r, 1'b0});
            in_nrow  = NR_W'({in_r, 1'b0});
            in_ybase = YB_W'($signed({1'b0, in_py})) - YB_W'($signed({1'b0, in_r}));
            in_xs    = (PW + 1)'($signed({1'b0, in_px})) - (PW + 1)'($signed({1'b0, in_r}));
        end else begin
            in_ncol  = (int'(in_sw) > MAX_WIDTH) ? NC_W'(MAX_WIDTH) : NC_W'(in_sw);
            in_nrow  = (int'(in_sh) > HEIGHT) ? NR_W'(HEIGHT) : NR_W'(in_sh);
            in_ybase = YB_W'($signed({1'b0, in_py}));
            in_xs    = (PW + 1)'($signed({1'b0, in_px}));
        end
        in_xmag = in_xs[PW] ? (PW + 1)'(-in_xs) : (PW + 1)'(in_xs);
    end

    assign s_acc = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Remainder unit: one dividend bit a cycle, restoring
    // ------------------------------------------------------------------
    logic [WW:0]   rem_trial;
    logic [WW-1:0] rem_next;
    logic [XW-1:0] x_start;

    assign rem_trial = {rem_reg, div_reg[PW-1]};
    assign rem_next  = (rem_trial >= {1'b0, eff_w}) ? WW'(rem_trial - {1'b0, eff_w})
                                                    : WW'(rem_trial);
    // A negative start folds back from the top of the map
    assign x_start   = (neg_reg && rem_next != '0) ? XW'(eff_w - rem_next) : XW'(rem_next);

    // Column advance with wrap at the effective width
    logic [WW-1:0] x_inc;
    logic [XW-1:0] x_next;
    assign x_inc  = WW'(x_reg) + WW'(1);
    assign x_next = (x_inc == eff_w) ? '0 : XW'(x_inc);

    // ------------------------------------------------------------------
    // Per-column and per-cell arithmetic
    // ------------------------------------------------------------------
    logic signed [NC_W:0]  dx_s;
    logic [RW-1:0]         dx_mag;
    logic [SQ_W-1:0]       dx2_next;
    assign dx_s     = $signed({1'b0, ci_reg}) - (NC_W + 1)'($signed({1'b0, r_reg}));
    assign dx_mag   = dx_s[NC_W] ? RW'(-dx_s) : RW'(dx_s);
    assign dx2_next = SQ_W'(dx_mag) * SQ_W'(dx_mag);

    // Next square by (dy + 1)^2 = dy^2 + 2dy + 1
    logic signed [DY_W-1:0]   dy_s;
    logic signed [SQ_W+1:0]   dy2_sum;
    logic [SQ_W-1:0]          dy2_next;
    assign dy_s     = DY_W'($signed({1'b0, ri_reg})) - DY_W'($signed({1'b0, r_reg}));
    assign dy2_sum  = (SQ_W + 2)'($signed({2'b0, dy2_reg}))
                    + (SQ_W + 2)'($signed({dy_s, 1'b1}));
    assign dy2_next = dy2_sum[SQ_W-1:0];

    // Inside test: ((dx^2 + dy^2) << 2F) <= radius_q^2
    logic [SQ_W:0]   dist_sum;
    logic [DST_W-1:0] dist_q;
    logic            cell_in;
    assign dist_sum = {1'b0, dx2_reg} + {1'b0, dy2_reg};
    assign dist_q   = DST_W'(dist_sum) << (2 * RADIUS_FRAC_BITS);
    assign cell_in  = (mode_reg == MODE_RECT) ||
                      (DST_W'(dist_q) <= ((DST_W > LIM_W) ? DST_W'(lim_reg) : DST_W'(lim_reg)));

    // Row clamp to the map
    logic signed [Y_W-1:0] y_s;
    logic [YW-1:0]         y_idx;
    assign y_s = Y_W'(ybase_reg) + Y_W'($signed({1'b0, ri_reg}));
    always_comb begin
        if (y_s < 0) begin
            y_idx = '0;
        end else if (y_s > Y_W'(HEIGHT - 1)) begin
            y_idx = YW'(HEIGHT - 1);
        end else begin
            y_idx = y_s[YW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Memory: write on clear or write-back, read the current column always
    // ------------------------------------------------------------------
    assign mem_we    = (state_reg == ST_CLEAR) || (state_reg == ST_WB);
    assign mem_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg : x_reg;
    assign mem_wdata = (state_reg == ST_CLEAR) ? '0 : col_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            map_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= map_mem[x_reg];
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            map_width_reg <= MAP_WIDTH_RST;
            m_tvalid_reg  <= 1'b0;
            x_reg         <= '0;
        end else begin
            if (cfg_wr && paddr[2] == REG_MAP_WIDTH) begin
                map_width_reg <= pwdata[MW_W-1:0];
            end

            // Drop the result once the far side takes it, unless a new one replaces it
            if (m_tvalid_reg && m_tready && state_reg != ST_DONE) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + XW'(1);
                    if (clr_cnt_reg == XW'(MAX_WIDTH - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end

                ST_IDLE: begin
                    if (s_acc) begin
                        mode_reg  <= in_mode;
                        val_reg   <= in_val;
                        r_reg     <= in_r;
                        lim_reg   <= LIM_W'(in_rq) * LIM_W'(in_rq);
                        r2_reg    <= SQ_W'(in_r) * SQ_W'(in_r);
                        ncol_reg  <= in_ncol;
                        nrow_reg  <= in_nrow;
                        ybase_reg <= in_ybase;
                        neg_reg   <= in_xs[PW];
                        div_reg   <= in_xmag[PW-1:0];
                        rem_reg   <= '0;
                        step_reg  <= '0;
                        ci_reg    <= '0;
                        count_reg <= '0;
                        // Empty region: nothing to walk
                        if (in_ncol == '0 || in_nrow == '0) begin
                            state_reg <= ST_DONE;
                        end else begin
                            state_reg <= ST_MOD;
                        end
                    end
                end

                ST_MOD: begin
                    rem_reg  <= rem_next;
                    div_reg  <= {div_reg[PW-2:0], 1'b0};
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(PW - 1)) begin
                        x_reg     <= x_start;
                        state_reg <= ST_RD;
                    end
                end

                ST_RD: begin
                    state_reg <= ST_LD;
                end

                ST_LD: begin
                    col_reg   <= rdata_reg;
                    dx2_reg   <= dx2_next;
                    dy2_reg   <= r2_reg;
                    ri_reg    <= '0;
                    state_reg <= ST_ROW;
                end

                ST_ROW: begin
                    if (cell_in) begin
                        col_reg[y_idx] <= val_reg;
                        if (count_reg != '1) begin
                            count_reg <= count_reg + CNT_W'(1);
                        end
                    end
                    dy2_reg <= dy2_next;
                    ri_reg  <= ri_reg + NR_W'(1);
                    if (ri_reg == nrow_reg - NR_W'(1)) begin
                        state_reg <= ST_WB;
                    end
                end

                ST_WB: begin
                    // Write happens this cycle; the next read follows it
                    x_reg  <= x_next;
                    ci_reg <= ci_reg + NC_W'(1);
                    if (ci_reg == ncol_reg - NC_W'(1)) begin
                        state_reg <= ST_DONE;
                    end else begin
                        state_reg <= ST_RD;
                    end
                end

                ST_DONE: begin
                    // Hold until the output register is free
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_cnt_reg    <= count_reg;
                        state_reg    <= ST_IDLE;
                    end
                end

                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(m_cnt_reg);
    assign m_tuser  = 1'b1;

endmodule

@@ hdl/brcf_checker.sv @@
// brcf_checker: port-level assertions for bitmap_rect_circle_fill.
// Depends on brcf_pkg; bound to the top level at the end of this file.
module brcf_checker
    import brcf_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_TDATA_W-1:0]  m_tdata,
    input logic [0:0]            m_tuser
);

    // Reset clears the result and starts the clearing pass
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("result or command ready after reset");

    // One command at a time: no transfer in the cycle after a transfer
    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("command taken while another is in progress");

    // Count never exceeds the map size, fill bits stay zero, done flag is high
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (int'(m_tdata) <= MAX_CELLS) && m_tuser[0])
        else $error("result count out of range or done flag low");

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind bitmap_rect_circle_fill brcf_checker u_brcf_checker (.*);

@@ bench/fill_check_pkg.sv @@
// fill_check_pkg: command record and scoreboard for the bitmap fill bench.
// Predicts the cell count of each fill command and checks the result stream.
// Depends on brcf_pkg for geometry, widths and command codes.
`timescale 1ns / 1ps

package fill_check_pkg;
    import brcf_pkg::*;

    typedef struct packed {
        logic              mode;
        logic              set_value;
        logic [PX_W-1:0]   pos_x;
        logic [PY_W-1:0]   pos_y;
        logic [SW_W-1:0]   size_w;
        logic [SH_W-1:0]   size_h;
        logic [RQ_W-1:0]   radius_q;
    } fill_cmd_t;

    class fill_scoreboard;
        logic [CNT_W-1:0] expected_counts[$];
        logic [MW_W-1:0]  width_reg;
        int mismatches;
        int rects_seen;
        int circles_seen;
        int results_seen;
        longint largest_count;

        function new();
            width_reg     = MAP_WIDTH_RST;
            mismatches    = 0;
            rects_seen    = 0;
            circles_seen  = 0;
            results_seen  = 0;
            largest_count = 0;
        endfunction

        function void flag(string what, logic [31:0] want, logic [31:0] got);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s: expected %0d, got %0d", what, want, got);
        endfunction

        // Count of cell writes. Wrapping and clamping move cells about but
        // never change how many writes a region makes, so the count needs
        // only the command itself.
        function longint cells_for(fill_cmd_t c);
            longint n;
            longint w;
            longint h;
            longint r;
            longint lim;
            n = 0;
            if (c.mode == MODE_RECT) begin
                w = (c.size_w > MAX_WIDTH) ? MAX_WIDTH : c.size_w;
                h = (c.size_h > HEIGHT) ? HEIGHT : c.size_h;
                n = w * h;
            end else begin
                r   = c.radius_q >> RADIUS_FRAC_BITS;
                lim = longint'(c.radius_q) * longint'(c.radius_q);
                for (longint dx = -r; dx < r; dx++)
                    for (longint dy = -r; dy < r; dy++)
                        if (((dx * dx + dy * dy) << (2 * RADIUS_FRAC_BITS)) <= lim)
                            n++;
            end
            if (n > (longint'(1) << CNT_W) - 1)
                n = (longint'(1) << CNT_W) - 1;
            return n;
        endfunction

        function void note_command(fill_cmd_t c);
            longint n;
            n = cells_for(c);
            if (c.mode == MODE_RECT) rects_seen++;
            else circles_seen++;
            if (n > largest_count) largest_count = n;
            expected_counts = {expected_counts, CNT_W'(n)};
        endfunction

        function void check_result(logic done, logic [M_TDATA_W-1:0] data);
            logic [CNT_W-1:0] want;
            results_seen++;
            if (expected_counts.size() == 0) begin
                flag("result with no command outstanding", 0, 32'(data));
                return;
            end
            want = expected_counts.pop_front();
            if (done !== 1'b1) flag("done_res", 1, 32'(done));
            if (data[CNT_W-1:0] !== want) flag("cells_written", 32'(want), 32'(data[CNT_W-1:0]));
            if (data[M_TDATA_W-1:CNT_W] !== '0)
                flag("m_tdata fill bits", 0, 32'(data[M_TDATA_W-1:CNT_W]));
        endfunction

        function void write_reg(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
            if (addr[PADDR_W-1:2] == REG_MAP_WIDTH) width_reg = data[MW_W-1:0];
        endfunction

        function void check_readback(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] rd);
            if (addr[PADDR_W-1:2] == REG_MAP_WIDTH && rd !== PDATA_W'(width_reg))
                flag("map_width readback", 32'(width_reg), rd);
        endfunction

        function int pending();
            return expected_counts.size();
        endfunction

        function void finish();
            if (expected_counts.size() != 0)
                flag("results never delivered", 0, expected_counts.size());
        endfunction
    endclass

endpackage

@@ bench/testbench.sv @@
// testbench: self-checking bench for bitmap_rect_circle_fill.
// Drives fill commands and register accesses, predicts each cell count in the
// scoreboard of fill_check_pkg; depends on brcf_pkg and the block's RTL.
`timescale 1ns / 1ps

module testbench;
    import brcf_pkg::*;
    import fill_check_pkg::*;

    // Length of the deliberate receiver hold-off, in clock cycles
    localparam int HOLD_CYCLES = 3000;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;

    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // tdata: set_value, pos_x, pos_y, size_w, size_h, radius_q, zero fill
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    // tuser: mode
    logic [0:0]           s_tuser  = '0;

    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // tdata: cells_written, zero fill
    logic [M_TDATA_W-1:0] m_tdata;
    // tuser: done_res
    logic [0:0]           m_tuser;

    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [PADDR_W-1:0]   paddr    = '0;
    logic [PDATA_W-1:0]   pwdata   = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    fill_scoreboard sb = new();

    // Hold-off requests from the stimulus, served by the result sink
    int hold_requests = 0;
    int hold_served   = 0;
    // Set to run a phase with no idling on the respective side
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    int reg_accesses = 0;

    bitmap_rect_circle_fill DUT (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Safety net against a hung block
    initial begin
        #150_000_000;
        $display("status: fail");
        $finish;
    end

    // Idle length: mostly short, now and then long
    function automatic int idle_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 70) return $urandom_range(1, 3);
        if (p < 92) return $urandom_range(4, 10);
        return $urandom_range(20, 80);
    endfunction

    // Result sink: check every transfer, then choose tready for the next edge.
    // Sample before any update of this edge lands, so the view is the
    // pre-edge one whatever the process order.
    initial begin : result_sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid === 1'b1 && m_tready)
                sb.check_result(m_tuser[0], m_tdata);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (hold_requests != hold_served) begin
                // long hold-off: let the block fill up and back-pressure its input
                hold_served++;
                hold_left = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!rx_steady && $urandom_range(0, 99) < 25) begin
                stall_left = idle_len() - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Offer one command and hold it until the transfer completes. tvalid is
    // lowered only ahead of a gap, so back-to-back commands keep it high.
    task automatic send_cmd(input fill_cmd_t c);
        if (!tx_steady && $urandom_range(0, 99) < 40) begin
            s_tvalid <= 1'b0;
            repeat (idle_len()) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c.mode;
        s_tdata  <= S_TDATA_W'({c.radius_q, c.size_h, c.size_w, c.pos_y, c.pos_x,
                                c.set_value});
        do @(posedge aclk); while (s_tready !== 1'b1);
        sb.note_command(c);
    endtask

    task automatic fill(input logic mode, input logic val, input int x, input int y,
                        input int w, input int h, input int rq);
        fill_cmd_t c;
        c.mode      = mode;
        c.set_value = val;
        c.pos_x     = PX_W'(x);
        c.pos_y     = PY_W'(y);
        c.size_w    = SW_W'(w);
        c.size_h    = SH_W'(h);
        c.radius_q  = RQ_W'(rq);
        send_cmd(c);
    endtask

    // Drop tvalid and hold until every outstanding result has arrived
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    // One register transfer: setup cycle, then access until pready.
    // Reads are checked against the shadow copy of the register.
    task automatic reg_access(input logic wr, input logic [PADDR_W-1:0] addr,
                              input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        if (wr) sb.write_reg(addr, data);
        else sb.check_readback(addr, prdata);
        reg_accesses++;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_width(input int w);
        reg_access(1'b1, PADDR_W'({REG_MAP_WIDTH, 2'b00}), PDATA_W'(w));
        reg_access(1'b0, PADDR_W'({REG_MAP_WIDTH, 2'b00}), '0);
    endtask

    function automatic fill_cmd_t random_cmd();
        fill_cmd_t c;
        int pick;
        c.mode      = ($urandom_range(0, 99) < 40) ? MODE_CIRCLE : MODE_RECT;
        c.set_value = 1'($urandom_range(0, 1));
        c.pos_x     = PX_W'($urandom);
        c.pos_y     = PY_W'($urandom);
        // the field unused by the shape stays random to show it is ignored
        c.size_w    = SW_W'($urandom);
        c.size_h    = SH_W'($urandom);
        c.radius_q  = RQ_W'($urandom);
        pick = $urandom_range(0, 99);
        if (c.mode == MODE_RECT) begin
            if (pick < 10) begin
                // wide strip, up to past the map width
                c.size_w = SW_W'($urandom_range(0, 2047));
                c.size_h = SH_W'($urandom_range(0, 2));
            end else if (pick < 20) begin
                // tall strip, up to past the map height
                c.size_w = SW_W'($urandom_range(0, 2));
                c.size_h = SH_W'($urandom_range(0, 511));
            end else begin
                c.size_w = SW_W'($urandom_range(0, 40));
                c.size_h = SH_W'($urandom_range(0, 40));
            end
        end else begin
            if (pick < 8) c.radius_q = RQ_W'($urandom_range(0, 31));
            else if (pick < 92) c.radius_q = RQ_W'($urandom_range(16, 511));
            else c.radius_q = RQ_W'($urandom_range(512, 1023));
        end
        return c;
    endfunction

    task automatic random_phase(input int n_items, input int hold_at, input int pause_at);
        for (int i = 0; i < n_items; i++) begin
            if (i == hold_at) hold_requests++;
            if (i == pause_at) wait_for_results();
            send_cmd(random_cmd());
        end
        wait_for_results();
    endtask

    initial begin : stimulus
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        // hold through the clearing pass of the map
        do @(posedge aclk); while (s_tready !== 1'b1);
        reg_access(1'b0, PADDR_W'({REG_MAP_WIDTH, 2'b00}), '0);

        // Directed commands at the reset width
        fill(MODE_RECT,   1'b1,    0,   0,    0,   7,    0);   // zero width
        fill(MODE_RECT,   1'b1,    5,   5,    9,   0, 4095);   // zero height
        fill(MODE_RECT,   1'b1,    0,   0,    1,   1,    0);
        fill(MODE_RECT,   1'b0, 1023, 255,    1,   1,    0);   // far corner
        fill(MODE_RECT,   1'b1, 1020,  10, 2047,   1,    0);   // width saturates, wraps
        fill(MODE_RECT,   1'b0,    3, 255,    1, 511,    0);   // height saturates, rows clamp
        fill(MODE_RECT,   1'b1, 1023, 255, 1024, 256,    0);   // full-map size, rows clamp to row 255
        fill(MODE_RECT,   1'b0, 1022, 100,    5,   3,    0);   // wraps right
        fill(MODE_CIRCLE, 1'b1,  500, 100, 2047, 511,   15);   // radius below one cell
        fill(MODE_CIRCLE, 1'b1,  500, 100,    0,   0,   16);
        fill(MODE_CIRCLE, 1'b0,    0,   0,    3,   3,   40);   // wraps left, clamps top
        fill(MODE_CIRCLE, 1'b1, 1023, 255, 1024, 256, 4095);   // largest radius
        fill(MODE_CIRCLE, 1'b0,  512, 128,    0,   0,   17);   // fractional radius
        wait_for_results();

        // A width of zero acts as one column
        set_width(0);
        fill(MODE_RECT,   1'b1, 1023,   7,    4,   2,    0);
        fill(MODE_CIRCLE, 1'b1,  700,   3,    0,   0,   48);
        wait_for_results();

        // Above the maximum the width saturates; the register keeps its value
        set_width(2047);
        fill(MODE_RECT,   1'b1, 1023,   0,    3,   3,    0);
        wait_for_results();
        // write to an index with no register: must leave map_width alone
        reg_access(1'b1, PADDR_W'(4), PDATA_W'(7));
        reg_access(1'b0, PADDR_W'({REG_MAP_WIDTH, 2'b00}), '0);

        // Random phases; the first pauses mid-way until all results are in
        set_width(1);
        random_phase(31, -1, 17);
        // long receiver hold-off while commands keep coming
        set_width($urandom_range(2, 1023));
        random_phase(31, 0, -1);
        // no idling on either side
        set_width(1024);
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        random_phase(31, -1, -1);
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        set_width($urandom_range(1, 1024));
        random_phase(31, 20, -1);

        // quiet period: nothing further may appear
        repeat (200) @(posedge aclk);
        sb.finish();
        $display("covered %0d rectangles and %0d circles, %0d results, largest count %0d",
                 sb.rects_seen, sb.circles_seen, sb.results_seen, sb.largest_count);
        $display("%0d register transfers, %0d receiver hold-offs, %0d mismatches",
                 reg_accesses, hold_served, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ bitmap_rect_circle_fill.f @@
hdl/brcf_pkg.sv
hdl/bitmap_rect_circle_fill.sv
hdl/brcf_checker.sv
bench/fill_check_pkg.sv
bench/testbench.sv
